### rtl/pfi_pkg.sv
// Shared types, command codes and saturation helpers for the particle force integrator.
`default_nettype none

package pfi_pkg;

	localparam logic [3:0] CMD_CLEAR     = 4'd0;
	localparam logic [3:0] CMD_ADD       = 4'd1;
	localparam logic [3:0] CMD_DAMP      = 4'd2;
	localparam logic [3:0] CMD_REPEL     = 4'd3;
	localparam logic [3:0] CMD_ATTRACT   = 4'd4;
	localparam logic [3:0] CMD_CW        = 4'd5;
	localparam logic [3:0] CMD_CCW       = 4'd6;
	localparam logic [3:0] CMD_LOAD      = 4'd7;
	localparam logic [3:0] CMD_INTEGRATE = 4'd8;

	localparam logic [1:0] REG_DAMPING = 2'd0;
	localparam logic [1:0] REG_WIDTH   = 2'd1;
	localparam logic [1:0] REG_HEIGHT  = 2'd2;

	localparam logic [15:0] DAMPING_RESET = 16'd5898;
	localparam logic [15:0] WIDTH_RESET   = 16'd1024;
	localparam logic [15:0] HEIGHT_RESET  = 16'd768;

	localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

	// Request to the shared divider: remainder seed, low numerator bits
	// (shifted in from the top) and divisor, for a given number of steps.
	typedef struct packed {
		logic        start;
		logic [30:0] rem0;
		logic [30:0] lo;
		logic [30:0] den;
		logic [4:0]  steps;
	} div_req_t;

	function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
		logic signed [31:0] r;
		if (v > 34'sd2147483647)
			r = SAT_MAX;
		else if (v < -34'sd2147483648)
			r = SAT_MIN;
		else
			r = v[31:0];
		return r;
	endfunction

	function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
		input logic signed [31:0] b);
		return sat32({{2{a[31]}}, a} + {{2{b[31]}}, b});
	endfunction

	function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
		input logic signed [31:0] b);
		return sat32({{2{a[31]}}, a} - {{2{b[31]}}, b});
	endfunction

	function automatic logic signed [31:0] neg_sat(input logic signed [31:0] v);
		logic signed [31:0] r;
		if (v == SAT_MIN)
			r = SAT_MAX;
		else
			r = -v;
		return r;
	endfunction

endpackage

`default_nettype wire

### rtl/pfi_mul.sv
// Shared registered 33x33 signed multiplier.
`default_nettype none

module pfi_mul
	import pfi_pkg::*;
(
	input  wire logic               clk,
	input  wire logic signed [32:0] a,
	input  wire logic signed [32:0] b,
	output      logic signed [65:0] p_q
);

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

endmodule

`default_nettype wire

### rtl/pfi_sqrt.sv
// Bit-serial integer square root, one result bit per cycle.
`default_nettype none

module pfi_sqrt
	import pfi_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [61:0] radicand,
	output      logic        busy,
	output      logic [30:0] root_q
);

	logic [61:0] rad_q;
	logic [32:0] rem_q;
	logic [4:0]  cnt_q;
	logic [34:0] r2;
	logic [34:0] trial;
	logic        fit;

	assign r2    = {rem_q, rad_q[61:60]};
	assign trial = {2'b00, root_q, 2'b01};
	assign fit   = r2 >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy  <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy  <= 1'b1;
			cnt_q <= 5'd31;
		end else if (busy) begin
			cnt_q <= cnt_q - 5'd1;
			if (cnt_q == 5'd1)
				busy <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy) begin
			rad_q <= {rad_q[59:0], 2'b00};
			if (fit) begin
				rem_q  <= 33'(r2 - trial);
				root_q <= {root_q[29:0], 1'b1};
			end else begin
				rem_q  <= r2[32:0];
				root_q <= {root_q[29:0], 1'b0};
			end
		end
	end

endmodule

`default_nettype wire

### rtl/pfi_div.sv
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none

module pfi_div
	import pfi_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire div_req_t    req,
	output      logic        busy,
	output      logic [30:0] quot_q
);

	logic [30:0] rem_q;
	logic [30:0] lo_q;
	logic [30:0] den_q;
	logic [4:0]  cnt_q;
	logic [31:0] t;
	logic        fit;

	assign t   = {rem_q, lo_q[30]};
	assign fit = t >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy  <= 1'b0;
			cnt_q <= '0;
		end else if (req.start) begin
			busy  <= 1'b1;
			cnt_q <= req.steps;
		end else if (busy) begin
			cnt_q <= cnt_q - 5'd1;
			if (cnt_q == 5'd1)
				busy <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= req.rem0;
			lo_q   <= req.lo;
			den_q  <= req.den;
			quot_q <= '0;
		end else if (busy) begin
			lo_q <= {lo_q[29:0], 1'b0};
			if (fit) begin
				rem_q  <= 31'(t - {1'b0, den_q});
				quot_q <= {quot_q[29:0], 1'b1};
			end else begin
				rem_q  <= t[30:0];
				quot_q <= {quot_q[29:0], 1'b0};
			end
		end
	end

endmodule

`default_nettype wire

### rtl/particle_force_integrator.sv
// Top level: sequencer and state of the 2D particle force integrator.
//
// One particle in Q16.16: position, velocity and accumulated force. Each
// request on the s_ channel carries a command; every request returns exactly
// one result on the m_ channel holding the whole state after the command,
// with the field hit flag in m_tuser.
// Requests are taken only while the block is idle; s_tready is low from
// acceptance until the result has been taken on the m_ side.
// Clear, add, load and unknown codes end after the execute state; integrate
// adds a position step, damp a step per force axis. A field command that hits
// runs the square root on its own unit, then the falloff ratio and two push
// divisions on one shared divider, with one shared registered multiplier and
// sequencing states between. A miss ends after the box or circle test; a
// particle on the center ends after the square root. With m_tready high the
// block goes back to idle, where the next request is taken. When m_tready is
// low the result holds on m_tdata and no new request enters. Reset clears the
// particle state to zero and loads the default damping gain and area size.
// cfg_we writes a register; the user must write only while idle (unenforced).
`default_nettype none

module particle_force_integrator
	import pfi_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [15:0]  cfg_data,
	input  wire logic         s_tvalid,
	output      logic         s_tready,
	// cmd[3:0], arg_x[35:4], arg_y[67:36], radius_or_vx[99:68],
	// strength_or_vy[131:100], zero pad
	input  wire logic [135:0] s_tdata,
	output      logic         m_tvalid,
	input  wire logic         m_tready,
	// pos_x, pos_y, vel_x, vel_y, force_x, force_y, 32 bits each from bit 0
	output      logic [191:0] m_tdata,
	// field_hit
	output      logic [0:0]   m_tuser
);

	typedef enum logic [18:0] {
		ST_IDLE   = 19'b000_0000_0000_0000_0001,
		ST_EXEC   = 19'b000_0000_0000_0000_0010,
		ST_INT2   = 19'b000_0000_0000_0000_0100,
		ST_DAMP1  = 19'b000_0000_0000_0000_1000,
		ST_DAMP2  = 19'b000_0000_0000_0001_0000,
		ST_TEST   = 19'b000_0000_0000_0010_0000,
		ST_SQY    = 19'b000_0000_0000_0100_0000,
		ST_SQR    = 19'b000_0000_0000_1000_0000,
		ST_CMP    = 19'b000_0000_0001_0000_0000,
		ST_SQRT   = 19'b000_0000_0010_0000_0000,
		ST_PCT    = 19'b000_0000_0100_0000_0000,
		ST_K      = 19'b000_0000_1000_0000_0000,
		ST_TXM    = 19'b000_0001_0000_0000_0000,
		ST_TXD    = 19'b000_0010_0000_0000_0000,
		ST_TXW    = 19'b000_0100_0000_0000_0000,
		ST_TYD    = 19'b000_1000_0000_0000_0000,
		ST_TYW    = 19'b001_0000_0000_0000_0000,
		ST_APPLY  = 19'b010_0000_0000_0000_0000,
		ST_OUT    = 19'b100_0000_0000_0000_0000
	} state_t;

	state_t state_q;

	logic [15:0] gain_q, width_q, height_q;
	logic signed [31:0] px_q, py_q, vx_q, vy_q, fx_q, fy_q;
	logic        hit_q;

	logic [3:0]         cmd_q;
	logic signed [31:0] ax_q, ay_q, rv_q, sv_q;
	logic signed [32:0] dx_q, dy_q;
	logic [62:0]        sum_q;
	logic signed [31:0] k_q, tx_q, ty_q;
	logic               neg_q;

	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] p_q;
	logic               sqrt_busy;
	logic [30:0]        root_dist;
	div_req_t           dreq;
	logic               div_busy;
	logic [30:0]        quot;

	logic               accept;
	logic [32:0]        adx, ady;
	logic signed [65:0] p_rnd;
	logic signed [31:0] term;
	logic signed [65:0] p_mag;
	logic signed [31:0] q_signed;
	logic signed [31:0] px_new, py_new;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = (state_q == ST_OUT);
	assign m_tdata  = {fy_q, fx_q, vy_q, vx_q, py_q, px_q};
	assign m_tuser  = hit_q;

	pfi_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (p_q)
	);

	pfi_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    ((state_q == ST_CMP) && (sum_q < 63'(p_q[62:0]))),
		.radicand (sum_q[61:0]),
		.busy     (sqrt_busy),
		.root_q   (root_dist)
	);

	pfi_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.busy   (div_busy),
		.quot_q (quot)
	);

	assign adx = dx_q[32] ? 33'(-dx_q) : 33'(dx_q);
	assign ady = dy_q[32] ? 33'(-dy_q) : 33'(dy_q);

	// Truncate toward zero on the divide by 65536
	assign p_rnd = p_q + (p_q[65] ? 66'sd65535 : 66'sd0);
	assign term  = p_rnd[47:16];

	assign p_mag    = p_q[65] ? -p_q : p_q;
	assign q_signed = neg_q ? -$signed({1'b0, quot}) : $signed({1'b0, quot});

	assign px_new = sat_add(px_q, vx_q);
	assign py_new = sat_add(py_q, vy_q);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_EXEC: begin
				mul_a = {vx_q[31], vx_q};
				mul_b = {17'd0, gain_q};
			end
			ST_DAMP1: begin
				mul_a = {vy_q[31], vy_q};
				mul_b = {17'd0, gain_q};
			end
			ST_TEST: begin
				mul_a = dx_q;
				mul_b = dx_q;
			end
			ST_SQY: begin
				mul_a = dy_q;
				mul_b = dy_q;
			end
			ST_SQR: begin
				mul_a = {rv_q[31], rv_q};
				mul_b = {rv_q[31], rv_q};
			end
			ST_PCT: begin
				mul_a = {17'd0, quot[15:0]};
				mul_b = {sv_q[31], sv_q};
			end
			ST_TXM: begin
				mul_a = dx_q;
				mul_b = {k_q[31], k_q};
			end
			ST_TXD, ST_TXW: begin
				mul_a = dy_q;
				mul_b = {k_q[31], k_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		dreq = '0;
		case (state_q)
			ST_SQRT: begin
				dreq.start = !sqrt_busy && (root_dist != '0);
				dreq.rem0  = 31'(rv_q[30:0] - root_dist);
				dreq.lo    = '0;
				dreq.den   = rv_q[30:0];
				dreq.steps = 5'd16;
			end
			ST_TXD, ST_TYD: begin
				dreq.start = 1'b1;
				dreq.rem0  = p_mag[61:31];
				dreq.lo    = p_mag[30:0];
				dreq.den   = root_dist;
				dreq.steps = 5'd31;
			end
			default: dreq = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q   <= DAMPING_RESET;
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DAMPING: gain_q   <= cfg_data;
				REG_WIDTH:   width_q  <= cfg_data;
				REG_HEIGHT:  height_q <= cfg_data;
				default:     ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= s_tdata[3:0];
			ax_q  <= s_tdata[35:4];
			ay_q  <= s_tdata[67:36];
			rv_q  <= s_tdata[99:68];
			sv_q  <= s_tdata[131:100];
		end
		if (state_q == ST_EXEC) begin
			dx_q <= {px_q[31], px_q} - {ax_q[31], ax_q};
			dy_q <= {py_q[31], py_q} - {ay_q[31], ay_q};
		end
		if (state_q == ST_SQY)
			sum_q <= 63'(p_q[61:0]);
		if (state_q == ST_SQR)
			sum_q <= sum_q + 63'(p_q[61:0]);
		if (state_q == ST_K)
			k_q <= term;
		if (state_q == ST_TXD || state_q == ST_TYD)
			neg_q <= p_q[65];
		if (state_q == ST_TXW && !div_busy)
			tx_q <= q_signed;
		if (state_q == ST_TYW && !div_busy)
			ty_q <= q_signed;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			px_q    <= '0;
			py_q    <= '0;
			vx_q    <= '0;
			vy_q    <= '0;
			fx_q    <= '0;
			fy_q    <= '0;
			hit_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						hit_q   <= 1'b0;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					case (cmd_q)
						CMD_CLEAR: begin
							fx_q    <= '0;
							fy_q    <= '0;
							state_q <= ST_OUT;
						end
						CMD_ADD: begin
							fx_q    <= sat_add(fx_q, ax_q);
							fy_q    <= sat_add(fy_q, ay_q);
							state_q <= ST_OUT;
						end
						CMD_DAMP: state_q <= ST_DAMP1;
						CMD_REPEL, CMD_ATTRACT, CMD_CW, CMD_CCW: state_q <= ST_TEST;
						CMD_LOAD: begin
							px_q    <= ax_q;
							py_q    <= ay_q;
							vx_q    <= rv_q;
							vy_q    <= sv_q;
							state_q <= ST_OUT;
						end
						CMD_INTEGRATE: begin
							vx_q    <= sat_add(vx_q, fx_q);
							vy_q    <= sat_add(vy_q, fy_q);
							state_q <= ST_INT2;
						end
						default: state_q <= ST_OUT;
					endcase
				end
				ST_INT2: begin
					px_q <= px_new;
					py_q <= py_new;
					if (px_new[31] || ({2'b00, px_new} > {2'b00, width_q, 16'd0}))
						vx_q <= neg_sat(vx_q);
					if (py_new[31] || ({2'b00, py_new} > {2'b00, height_q, 16'd0}))
						vy_q <= neg_sat(vy_q);
					state_q <= ST_OUT;
				end
				ST_DAMP1: begin
					fx_q    <= sat_sub(fx_q, term);
					state_q <= ST_DAMP2;
				end
				ST_DAMP2: begin
					fy_q    <= sat_sub(fy_q, term);
					state_q <= ST_OUT;
				end
				ST_TEST: begin
					if (!rv_q[31] && (rv_q != '0) && (adx < {1'b0, rv_q})
						&& (ady < {1'b0, rv_q}))
						state_q <= ST_SQY;
					else
						state_q <= ST_OUT;
				end
				ST_SQY: state_q <= ST_SQR;
				ST_SQR: state_q <= ST_CMP;
				ST_CMP: begin
					if (sum_q < 63'(p_q[62:0])) begin
						hit_q   <= 1'b1;
						state_q <= ST_SQRT;
					end else begin
						state_q <= ST_OUT;
					end
				end
				ST_SQRT: begin
					if (!sqrt_busy) begin
						// Particle on the center: hit with no push
						if (root_dist == '0)
							state_q <= ST_OUT;
						else
							state_q <= ST_PCT;
					end
				end
				ST_PCT: begin
					if (!div_busy)
						state_q <= ST_K;
				end
				ST_K:   state_q <= ST_TXM;
				ST_TXM: state_q <= ST_TXD;
				ST_TXD: state_q <= ST_TXW;
				ST_TXW: begin
					if (!div_busy)
						state_q <= ST_TYD;
				end
				ST_TYD: state_q <= ST_TYW;
				ST_TYW: begin
					if (!div_busy)
						state_q <= ST_APPLY;
				end
				ST_APPLY: begin
					case (cmd_q)
						CMD_REPEL: begin
							fx_q <= sat_add(fx_q, tx_q);
							fy_q <= sat_add(fy_q, ty_q);
						end
						CMD_ATTRACT: begin
							fx_q <= sat_sub(fx_q, tx_q);
							fy_q <= sat_sub(fy_q, ty_q);
						end
						CMD_CW: begin
							fx_q <= sat_sub(fx_q, ty_q);
							fy_q <= sat_add(fy_q, tx_q);
						end
						default: begin
							fx_q <= sat_add(fx_q, ty_q);
							fy_q <= sat_sub(fy_q, tx_q);
						end
					endcase
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (m_tready)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire
